// File: design/pmft_pkg.sv
// Package for the page-mapped flash translation engine.
// Holds the status codes and the command codes used by the top level.
package pmft_pkg;
  localparam logic [1:0] ST_READ_MAPPED   = 2'd0;
  localparam logic [1:0] ST_READ_UNMAPPED = 2'd1;
  localparam logic [1:0] ST_WRITE_PLACED  = 2'd2;
  localparam logic [1:0] ST_FULL          = 2'd3;
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;
endpackage

// File: design/pmft_if.sv
// Valid/ready channel interfaces for the flash translation engine.
// Depends on nothing; payload widths follow the request and response fields.
interface pmft_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [11:0] logical_page;
  modport source (output valid, cmd, logical_page, input ready);
  modport sink   (input valid, cmd, logical_page, output ready);
endinterface

interface pmft_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [1:0] package_index;
  logic       die_index;
  logic       plane_index;
  logic [3:0] block_index;
  logic [4:0] page_index;
  logic       replaced;
  modport source (output valid, status, package_index, die_index, plane_index,
                  block_index, page_index, replaced, input ready);
  modport sink   (input valid, status, package_index, die_index, plane_index,
                  block_index, page_index, replaced, output ready);
endinterface

// File: design/page_mapped_flash_translation.sv
// Top level of the page-mapped flash translation engine.
// Depends on pmft_pkg and the channel interfaces in pmft_if.
//
//   channel  dir  fields
//   req      in   cmd, logical_page
//   rsp      out  status, package, die, plane, block, page, replaced
//
// After reset a clearing pass zeroes the map memory and, alongside,
// every row of the used memory; no request is taken meanwhile.
// A read result is loaded after the states LOOK, DEC and OUT; a write passes LOOK,
// DEC, FREE, SCAN, TEST and OUT when the write-pointer block has a free page, plus DONE,
// SCAN and TEST for every further block row scanned (up to 255 more). The next request is taken the cycle after.
// Both memories have one read and one write port, read data registered.
// A finished result waits in the output register; a new request is taken
// while it waits, and a second result stalls until the first transfer.
module page_mapped_flash_translation (
  input logic clk,
  input logic rst,
  pmft_req_if.sink   req,
  pmft_rsp_if.source rsp
);
  localparam int PGW = 5;
  localparam int BKW = 4;
  localparam int PHW = 13;           // physical page number
  localparam int RBW = 8;            // global block row
  localparam int LPW = 12;
  localparam int PAGES = 32;

  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_LOOK = 4'd2, S_DEC = 4'd3,
                         S_FREE = 4'd4, S_SCAN = 4'd5, S_TEST = 4'd6, S_DONE = 4'd7,
                         S_OUT = 4'd8;

  logic [3:0] state;
  logic [LPW-1:0] clr_cnt;

  // map memory: valid plus physical page
  logic [PHW:0]   map_mem [0:(1<<LPW)-1];
  logic [PHW:0]   map_rd;
  logic [LPW-1:0] map_ra, map_wa;
  logic [PHW:0]   map_wd;
  logic           map_we;

  // used memory: one row of PAGES bits per block
  logic [PAGES-1:0] used_mem [0:(1<<RBW)-1];
  logic [PAGES-1:0] used_rd, used_wd;
  logic [RBW-1:0]   used_ra, used_wa;
  logic             used_we;

  logic           cmd_q;
  logic [LPW-1:0] lp_q;
  logic           mapped_q;
  logic [PHW-1:0] old_q;
  logic [RBW-1:0] row, row_start;
  logic [RBW:0]   scanned;
  logic [PAGES-1:0] row_bits;
  logic [PGW-1:0] pg_sel;
  logic           pg_found;
  logic [1:0] ptr_pkg;
  logic       ptr_die, ptr_pl;

  logic [1:0]     res_status;
  logic [PHW-1:0] res_phys;
  logic           res_repl;

  logic [1:0]     o_status;
  logic [PHW-1:0] o_phys;
  logic           o_repl;
  logic           o_valid;

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    map_rd <= map_mem[map_ra];
    if (used_we) used_mem[used_wa] <= used_wd;
    used_rd <= used_mem[used_ra];
  end

  // first free page in the current row
  always_comb begin
    pg_found = 1'b0;
    pg_sel = '0;
    for (int i = PAGES - 1; i >= 0; i--) begin
      if (!row_bits[i]) begin
        pg_found = 1'b1;
        pg_sel = PGW'(i);
      end
    end
  end

  assign row_start = {ptr_pkg, ptr_die, ptr_pl, {BKW{1'b0}}};
  assign req.ready = (state == S_IDLE);

  always_comb begin
    map_ra = lp_q;
    map_we = 1'b0;
    map_wa = lp_q;
    map_wd = {1'b1, row, pg_sel};
    used_ra = row;
    used_we = 1'b0;
    used_wa = row;
    used_wd = row_bits;
    if (req.valid && req.ready) map_ra = req.logical_page;
    unique case (state)
      S_CLEAR: begin
        map_we = 1'b1;
        map_wa = clr_cnt;
        map_wd = '0;
        used_we = 1'b1;
        used_wa = clr_cnt[RBW-1:0];
        used_wd = '0;
      end
      S_DEC: used_ra = map_rd[PHW-1:PGW];
      S_FREE: begin
        if (mapped_q) begin
          used_we = 1'b1;
          used_wa = old_q[PHW-1:PGW];
          used_wd = used_rd & ~(PAGES'(1) << old_q[PGW-1:0]);
        end
        used_ra = row_start;
      end
      S_TEST: begin
        if (pg_found) begin
          used_we = 1'b1;
          used_wd = row_bits | (PAGES'(1) << pg_sel);
          map_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      o_valid <= 1'b0;
      ptr_pkg <= '0;
      ptr_die <= 1'b0;
      ptr_pl  <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (&clr_cnt) state <= S_IDLE;
        end
        S_IDLE: if (req.valid) begin
          cmd_q <= req.cmd;
          lp_q  <= req.logical_page;
          state <= S_LOOK;
        end
        S_LOOK: state <= S_DEC;   // map data lands at end of this cycle
        S_DEC: begin
          mapped_q <= map_rd[PHW];
          old_q    <= map_rd[PHW-1:0];
          if (cmd_q == pmft_pkg::CMD_READ) begin
            res_status <= map_rd[PHW] ? pmft_pkg::ST_READ_MAPPED
                                      : pmft_pkg::ST_READ_UNMAPPED;
            res_phys   <= map_rd[PHW] ? map_rd[PHW-1:0] : '0;
            res_repl   <= 1'b0;
            state      <= S_OUT;
          end else begin
            state <= S_FREE;
          end
        end
        S_FREE: begin
          row     <= row_start;
          scanned <= '0;
          state   <= S_SCAN;
        end
        S_SCAN: begin
          // forward the freed bit if this row was just written
          if (mapped_q && scanned == '0 && old_q[PHW-1:PGW] == row)
            row_bits <= used_rd & ~(PAGES'(1) << old_q[PGW-1:0]);
          else
            row_bits <= used_rd;
          state <= S_TEST;
        end
        S_TEST: begin
          if (pg_found) begin
            res_status <= pmft_pkg::ST_WRITE_PLACED;
            res_phys   <= {row, pg_sel};
            res_repl   <= mapped_q;
            ptr_pkg    <= ptr_pkg + 1'b1;
            if (&ptr_pkg) begin
              ptr_die <= ~ptr_die;
              if (ptr_die) ptr_pl <= ~ptr_pl;
            end
            state <= S_OUT;
          end else if (scanned == (RBW+1)'((1 << RBW) - 1)) begin
            res_status <= pmft_pkg::ST_FULL;
            res_phys   <= '0;
            res_repl   <= 1'b0;
            state      <= S_OUT;
          end else begin
            row     <= row + 1'b1;
            scanned <= scanned + 1'b1;
            state   <= S_DONE;
          end
        end
        S_DONE: state <= S_SCAN;  // read of the next row in flight
        S_OUT: if (!o_valid || rsp.ready) begin
          o_status <= res_status;
          o_phys   <= res_phys;
          o_repl   <= res_repl;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_OUT && (!o_valid || rsp.ready)) o_valid <= 1'b1;
      else if (rsp.valid && rsp.ready) o_valid <= 1'b0;
    end
  end

  assign rsp.valid         = o_valid;
  assign rsp.status        = o_status;
  assign rsp.package_index = o_phys[12:11];
  assign rsp.die_index     = o_phys[10];
  assign rsp.plane_index   = o_phys[9];
  assign rsp.block_index   = o_phys[8:5];
  assign rsp.page_index    = o_phys[4:0];
  assign rsp.replaced      = o_repl;
endmodule
